FILE: rtl/core/min_max_fifo_queue_core_defines.svh
// Assertion macros shared by the queue core modules.
// Each module that uses them has clk and rst_n in scope.
`ifndef MIN_MAX_FIFO_QUEUE_CORE_DEFINES_SVH
`define MIN_MAX_FIFO_QUEUE_CORE_DEFINES_SVH

// Check a property while out of reset.
`define MMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define MMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/mmq_pkg.sv
`timescale 1ns / 1ps

package mmq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned LEVELS = $clog2(DEPTH);
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-item result data that travels alongside the compare tree.
  typedef struct packed {
    val_t    front;
    occ_t    occupancy;
    status_t status;
  } meta_t;

endpackage

FILE: rtl/core/mmq_if.sv
`timescale 1ns / 1ps

interface mmq_in_if;
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  mmq_pkg::val_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface mmq_out_if;
  logic          valid;
  logic          ready;
  mmq_pkg::val_t front_value;
  mmq_pkg::val_t min_value;
  mmq_pkg::val_t max_value;
  mmq_pkg::occ_t occupancy;
  logic          is_empty;
  logic [1:0]    status;

  modport source (output valid, output front_value, output min_value, output max_value,
                  output occupancy, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input min_value, input max_value,
                  input occupancy, input is_empty, input status, output ready);
endinterface

FILE: rtl/core/mmq_cells.sv
`timescale 1ns / 1ps
`include "min_max_fifo_queue_core_defines.svh"

module mmq_cells (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [1:0]    op,
  input  mmq_pkg::val_t value,
  output mmq_pkg::val_t cells [mmq_pkg::DEPTH],
  output mmq_pkg::occ_t count,
  output mmq_pkg::meta_t meta
);

  mmq_pkg::val_t  cells_r [mmq_pkg::DEPTH];
  mmq_pkg::occ_t  count_r;
  mmq_pkg::occ_t  count_nxt;
  mmq_pkg::meta_t meta_r;
  mmq_pkg::meta_t meta_nxt;
  logic           enq_req;
  logic           deq_req;
  logic           full;
  logic           empty;
  logic           enq_ok;
  logic           deq_ok;

  assign enq_req = take && (op == mmq_pkg::OP_ENQ);
  assign deq_req = take && (op == mmq_pkg::OP_DEQ);
  assign full    = (count_r == mmq_pkg::OCC_W'(mmq_pkg::DEPTH));
  assign empty   = (count_r == '0);
  assign enq_ok  = enq_req && !full;
  assign deq_ok  = deq_req && !empty;

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + mmq_pkg::OCC_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - mmq_pkg::OCC_W'(1);
    end

    meta_nxt.occupancy = count_nxt;
    priority if (enq_req && full) begin
      meta_nxt.status = mmq_pkg::ST_FULL;
    end else if (deq_req && empty) begin
      meta_nxt.status = mmq_pkg::ST_EMPTY;
    end else begin
      meta_nxt.status = mmq_pkg::ST_OK;
    end

    priority if (deq_ok) begin
      meta_nxt.front = cells_r[1];
    end else if (enq_ok && empty) begin
      meta_nxt.front = value;
    end else begin
      meta_nxt.front = cells_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (take) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      meta_r <= meta_nxt;
    end
  end

  // Cell 0 is the front; dequeue shifts the row down, enqueue writes at the fill point.
  for (genvar i = 0; i < mmq_pkg::DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (deq_ok) begin
        if (i < mmq_pkg::DEPTH - 1) begin
          cells_r[i] <= cells_r[(i + 1) % mmq_pkg::DEPTH];
        end
      end else if (enq_ok && (count_r == mmq_pkg::OCC_W'(i))) begin
        cells_r[i] <= value;
      end
    end
    assign cells[i] = cells_r[i];
  end

  assign count = count_r;
  assign meta  = meta_r;

  `MMQ_ASSERT(a_count_bound, count_r <= mmq_pkg::OCC_W'(mmq_pkg::DEPTH), "count above depth")
  `MMQ_ASSERT(a_full_holds, (enq_req && full) |=> (count_r == $past(count_r)), "full enqueue moved count")
  `MMQ_ASSERT(a_empty_flag, (deq_req && empty) |=> (meta_r.status == mmq_pkg::ST_EMPTY), "empty dequeue not flagged")

endmodule

FILE: rtl/core/mmq_tree.sv
`timescale 1ns / 1ps

module mmq_tree (
  input  logic          clk,
  input  logic          adv,
  input  mmq_pkg::val_t cells [mmq_pkg::DEPTH],
  input  mmq_pkg::occ_t count,
  output mmq_pkg::val_t min_value,
  output mmq_pkg::val_t max_value
);

  mmq_pkg::val_t leaf_min [mmq_pkg::DEPTH];
  mmq_pkg::val_t leaf_max [mmq_pkg::DEPTH];
  mmq_pkg::val_t min_r [1:mmq_pkg::DEPTH-1];
  mmq_pkg::val_t max_r [1:mmq_pkg::DEPTH-1];

  // Empty cells are neutral: all ones for the minimum, zero for the maximum.
  for (genvar i = 0; i < mmq_pkg::DEPTH; i++) begin : g_leaf
    assign leaf_min[i] = (mmq_pkg::OCC_W'(i) < count) ? cells[i] : '1;
    assign leaf_max[i] = (mmq_pkg::OCC_W'(i) < count) ? cells[i] : '0;
  end

  // Heap-ordered nodes, one register level per tree level.
  for (genvar n = 1; n < mmq_pkg::DEPTH; n++) begin : g_node
    mmq_pkg::val_t a_min;
    mmq_pkg::val_t b_min;
    mmq_pkg::val_t a_max;
    mmq_pkg::val_t b_max;

    if (2 * n >= mmq_pkg::DEPTH) begin : g_bottom
      assign a_min = leaf_min[2 * n - mmq_pkg::DEPTH];
      assign b_min = leaf_min[2 * n + 1 - mmq_pkg::DEPTH];
      assign a_max = leaf_max[2 * n - mmq_pkg::DEPTH];
      assign b_max = leaf_max[2 * n + 1 - mmq_pkg::DEPTH];
    end else begin : g_inner
      assign a_min = min_r[2 * n];
      assign b_min = min_r[2 * n + 1];
      assign a_max = max_r[2 * n];
      assign b_max = max_r[2 * n + 1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        min_r[n] <= (b_min < a_min) ? b_min : a_min;
        max_r[n] <= (b_max > a_max) ? b_max : a_max;
      end
    end
  end

  assign min_value = min_r[1];
  assign max_value = max_r[1];

endmodule

FILE: rtl/core/min_max_fifo_queue_core.sv
`timescale 1ns / 1ps
// Pipeline: an input transfer first updates the queue row register, then passes one
//   register level per tree level (log2 of depth) before its result can transfer.
// Throughput: one item per cycle while the output slot is free or being drained; the
//   queue row updates on each transfer and the min/max tree is registered per level, so items overlap.
// Reset: synchronous active-low rst_n empties the queue and drops every item in flight;
//   cell contents are not cleared and are never shown while not holding an entry.
`include "min_max_fifo_queue_core_defines.svh"

module min_max_fifo_queue_core (
  input  logic clk,
  input  logic rst_n,
  mmq_in_if.sink    in_if,
  mmq_out_if.source out_if
);

  mmq_pkg::val_t  cells [mmq_pkg::DEPTH];
  mmq_pkg::occ_t  count;
  mmq_pkg::meta_t meta;
  mmq_pkg::val_t  root_min;
  mmq_pkg::val_t  root_max;

  // Stage valid bits: bit 0 is the queue state, bit LEVELS lines up with the tree root.
  logic [mmq_pkg::LEVELS:0] v_r;
  mmq_pkg::meta_t           meta_line_r [1:mmq_pkg::LEVELS];
  mmq_pkg::meta_t           meta_out;
  logic                     adv;
  logic                     take;
  logic                     has_entries;

  // Advance the whole pipeline whenever the output slot is free or being drained.
  assign adv         = !v_r[mmq_pkg::LEVELS] || out_if.ready;
  assign in_if.ready = adv;
  assign take        = in_if.valid && adv;

  // Queue row and counters: apply the operation on the transfer edge.
  mmq_cells u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .op    (in_if.op),
    .value (in_if.value),
    .cells (cells),
    .count (count),
    .meta  (meta)
  );

  // Registered min/max tree over the row; it samples the row as each item's operation left it.
  mmq_tree u_tree (
    .clk       (clk),
    .adv       (adv),
    .cells     (cells),
    .count     (count),
    .min_value (root_min),
    .max_value (root_max)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[mmq_pkg::LEVELS-1:0], take};
    end
  end

  // Delay front, occupancy and status to meet the tree root.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_line_r[1] <= meta;
      for (int k = 2; k <= mmq_pkg::LEVELS; k++) begin
        meta_line_r[k] <= meta_line_r[k-1];
      end
    end
  end

  assign meta_out    = meta_line_r[mmq_pkg::LEVELS];
  assign has_entries = (meta_out.occupancy != '0);

  // Drive zero for the values of an empty queue.
  assign out_if.valid       = v_r[mmq_pkg::LEVELS];
  assign out_if.front_value = has_entries ? meta_out.front : '0;
  assign out_if.min_value   = has_entries ? root_min : '0;
  assign out_if.max_value   = has_entries ? root_max : '0;
  assign out_if.occupancy   = meta_out.occupancy;
  assign out_if.is_empty    = !has_entries;
  assign out_if.status      = meta_out.status;

  `MMQ_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> !v_r[mmq_pkg::LEVELS], "result valid after reset")
  `MMQ_ASSERT(a_min_front, (out_if.valid && has_entries) |-> (root_min <= meta_out.front), "front below minimum")
  `MMQ_ASSERT(a_front_max, (out_if.valid && has_entries) |-> (meta_out.front <= root_max), "front above maximum")

endmodule
